[rtl/ddpid_pkg.sv]
// Shared types, constants and helper functions of the differential-drive PID controller.
package ddpid_pkg;

    localparam int SPD_W      = 16;
    localparam int BATT_W     = 14;
    localparam int PWM_W      = 12;
    localparam int GAIN_W     = 16;
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 34;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 56;
    localparam int DIV_W      = 48;
    localparam int DIV_BITS   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int SAT_IN_W   = 50;

    // Percent mode divides (FULL_BATTERY_MV * ideal_percent) / 256 by this.
    localparam logic [BATT_W-1:0] PCT_DIVISOR = BATT_W'(100);

    // Bit positions in control_flags.
    localparam int FLAG_PERCENT = 0;
    localparam int FLAG_GYRO    = 1;
    localparam int FLAG_LINE    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLAGS,
        REG_TARGET_SPEED,
        REG_TARGET_PERCENT,
        REG_ACCEL_STEP,
        REG_BRAKE_STEP,
        REG_LINEAR_GAINS,
        REG_ANGULAR_GAINS,
        REG_LINE_GAINS
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAMP,
        S_ERR,
        S_LIN_MAC,
        S_LIN_DRAIN,
        S_LIN_SAVE,
        S_LIN_DIVS,
        S_LIN_DIVW,
        S_ANG_MAC,
        S_ANG_DRAIN,
        S_VOLT,
        S_PWM_MAC,
        S_PWM_DRAIN,
        S_PWM_DIVS,
        S_PWM_DIVW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Saturate a signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(64'sh7FFF_FFFF);
        lo = -SAT_IN_W'(64'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

[rtl/ddpid_if.sv]
// Valid/ready channel interfaces for control ticks, PWM results and register writes.
interface ddpid_in_if;
    logic                                valid;
    logic                                ready;
    logic                                running;
    logic signed [ddpid_pkg::SPD_W-1:0]  left_speed;
    logic signed [ddpid_pkg::SPD_W-1:0]  right_speed;
    logic signed [ddpid_pkg::SPD_W-1:0]  gyro_rate;
    logic signed [ddpid_pkg::SPD_W-1:0]  line_position;
    logic        [ddpid_pkg::BATT_W-1:0] battery_mv;

    modport source (output valid, running, left_speed, right_speed, gyro_rate,
                    line_position, battery_mv, input ready);
    modport sink   (input valid, running, left_speed, right_speed, gyro_rate,
                    line_position, battery_mv, output ready);
endinterface

interface ddpid_out_if;
    logic                              valid;
    logic                              ready;
    logic [ddpid_pkg::PWM_W-1:0]       left_duty;
    logic [ddpid_pkg::PWM_W-1:0]       right_duty;
    logic                              stopped;

    modport source (output valid, left_duty, right_duty, stopped, input ready);
    modport sink   (input valid, left_duty, right_duty, stopped, output ready);
endinterface

interface ddpid_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ddpid_pkg::CFG_IDX_W-1:0]      index;
    logic [ddpid_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ddpid_mac.sv]
// Shared signed multiply-accumulate unit with a registered product.
module ddpid_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ddpid_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [ddpid_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [ddpid_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [ddpid_pkg::ACC_W-1:0]     o_acc
);

    logic signed [ddpid_pkg::PROD_W-1:0] r_prod;
    logic                                r_prod_vld;
    logic signed [ddpid_pkg::ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else if (i_ctl.clear) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_ctl.valid;
            if (r_prod_vld) begin
                r_acc <= r_acc + ddpid_pkg::ACC_W'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

[rtl/ddpid_div.sv]
// Iterative unsigned restoring divider, two quotient bits per cycle.
module ddpid_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ddpid_pkg::DIV_W-1:0]       i_dividend,
    input  logic [ddpid_pkg::BATT_W-1:0]      i_divisor,
    output ddpid_pkg::t_div_stat              o_stat,
    output logic [ddpid_pkg::DIV_W-1:0]       o_quotient
);

    localparam int ITERS = ddpid_pkg::DIV_W / ddpid_pkg::DIV_BITS;
    localparam int CNT_W = $clog2(ITERS);

    logic                              r_busy;
    logic                              r_done;
    logic [CNT_W-1:0]                  r_cnt;
    logic [ddpid_pkg::DIV_W-1:0]       r_quo;
    logic [ddpid_pkg::BATT_W-1:0]      r_rem;
    logic [ddpid_pkg::BATT_W-1:0]      r_dvs;
    logic [ddpid_pkg::DIV_W-1:0]       n_quo;
    logic [ddpid_pkg::BATT_W-1:0]      n_rem;

    always_comb begin
        logic [ddpid_pkg::BATT_W:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int j = 0; j < ddpid_pkg::DIV_BITS; j++) begin
            trial = {n_rem, n_quo[ddpid_pkg::DIV_W-1]};
            if (trial >= {1'b0, r_dvs}) begin
                trial = trial - {1'b0, r_dvs};
                n_quo = {n_quo[ddpid_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[ddpid_pkg::DIV_W-2:0], 1'b0};
            end
            n_rem = trial[ddpid_pkg::BATT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

[rtl/diff_drive_pid_motor_control.sv]
// Top level of the differential-drive PID motor controller with its sequencer.
//
// One control tick is one input transfer; it yields exactly one result transfer with the two
// motor PWM compare values. A tick with running low goes straight to the result step with
// the stop value and leaves all state alone. A running tick walks a small sequencer: the
// selected ramp and the error accumulators update, then one shared 18x34 multiply-accumulate
// unit forms the linear PD (or the percent-of-battery voltage) and the five-term angular PD
// plus line PID, and one shared divider maps each wheel voltage to PWM through
// v*(PWM_MAX/2)/battery_mv. The divider yields two quotient bits a cycle over a 48-bit
// dividend, and percent mode needs one more divide, by 100. The input channel is ready only
// while the sequencer is idle. A finished result waits in an output register, so the next
// tick may be taken while it is still pending. Register writes are always taken and are
// meant to happen only between ticks.
module diff_drive_pid_motor_control #(
    parameter int unsigned PWM_MAX         = 4095,
    parameter int unsigned PWM_STOP        = 0,
    parameter int unsigned PWM_MIN         = 0,
    parameter int unsigned FULL_BATTERY_MV = 8400
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ddpid_in_if.sink      i_in,
    ddpid_cfg_if.sink     i_cfg,
    ddpid_out_if.source   o_out
);

    localparam int unsigned STOP_SAT = (PWM_STOP > PWM_MAX) ? PWM_MAX : PWM_STOP;
    localparam logic [ddpid_pkg::PWM_W-1:0]   STOP_PWM = ddpid_pkg::PWM_W'(STOP_SAT);
    localparam logic signed [ddpid_pkg::MUL_A_W-1:0] HALF_PWM =
        ddpid_pkg::MUL_A_W'(PWM_MAX / 2);
    localparam logic signed [ddpid_pkg::MUL_A_W-1:0] FULL_MV =
        ddpid_pkg::MUL_A_W'(FULL_BATTERY_MV);
    localparam logic [48:0] STOP_W = 49'(PWM_STOP);
    localparam logic [48:0] MIN_W  = 49'(PWM_MIN);
    localparam logic [48:0] MAX_W  = 49'(PWM_MAX);

    // Configuration registers.
    logic [2:0]         r_flags;
    logic signed [15:0] r_tgt_speed;
    logic [6:0]         r_tgt_pct;
    logic [15:0]        r_accel;
    logic [15:0]        r_brake;
    logic [31:0]        r_lin_gains;
    logic [31:0]        r_ang_gains;
    logic [47:0]        r_line_gains;

    // Controller state kept from tick to tick.
    logic signed [31:0] r_ideal_speed;
    logic signed [31:0] r_ideal_pct;
    logic signed [31:0] r_speed_acc;
    logic signed [31:0] r_prev_speed;
    logic signed [31:0] r_turn_acc;
    logic signed [31:0] r_prev_turn;
    logic signed [15:0] r_line_now;
    logic signed [15:0] r_line_prev;
    logic signed [31:0] r_line_sum;

    // Latched tick inputs and working values.
    logic signed [15:0] r_left;
    logic signed [15:0] r_right;
    logic signed [15:0] r_gyro;
    logic signed [15:0] r_linepos;
    logic [13:0]        r_batt;
    logic signed [47:0] r_lin;
    logic signed [31:0] r_vl;
    logic signed [31:0] r_vr;
    logic               r_side;
    logic [2:0]         r_cnt;
    logic [11:0]        r_pwm_l;
    logic [11:0]        r_pwm_r;
    logic               r_stopped;

    // Output register.
    logic               r_out_vld;
    logic [11:0]        r_out_l;
    logic [11:0]        r_out_r;
    logic               r_out_stop;

    ddpid_pkg::t_state  r_state;
    ddpid_pkg::t_state  n_state;

    ddpid_pkg::t_mac_ctl                      mac_ctl;
    logic signed [ddpid_pkg::MUL_A_W-1:0]     mac_a;
    logic signed [ddpid_pkg::MUL_B_W-1:0]     mac_b;
    logic signed [ddpid_pkg::ACC_W-1:0]       mac_acc;
    logic                                     div_start;
    logic [ddpid_pkg::DIV_W-1:0]              div_dividend;
    logic [ddpid_pkg::BATT_W-1:0]             div_divisor;
    ddpid_pkg::t_div_stat                     div_stat;
    logic [ddpid_pkg::DIV_W-1:0]              div_quo;

    logic in_fire;
    logic out_load;
    logic pct_mode;
    logic [2:0] lin_last;

    assign in_fire  = i_in.valid && i_in.ready;
    assign pct_mode = r_flags[ddpid_pkg::FLAG_PERCENT];
    assign lin_last = pct_mode ? 3'd0 : 3'd1;
    assign out_load = (r_state == ddpid_pkg::S_DONE) && (!r_out_vld || o_out.ready);

    ddpid_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc)
    );

    ddpid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // Ramp of the selected ideal value toward its target, clamped so it never overshoots.
    logic signed [33:0] rp_cur;
    logic signed [33:0] rp_tgt;
    logic signed [33:0] rp_up;
    logic signed [33:0] rp_dn;
    logic signed [33:0] rp_new;

    always_comb begin
        rp_cur = pct_mode ? 34'(r_ideal_pct) : 34'(r_ideal_speed);
        rp_tgt = pct_mode ? $signed({19'd0, r_tgt_pct, 8'd0})
                          : $signed({{10{r_tgt_speed[15]}}, r_tgt_speed, 8'd0});
        rp_up  = rp_cur + $signed({18'd0, r_accel});
        rp_dn  = rp_cur - $signed({18'd0, r_brake});
        if (rp_cur < rp_tgt) begin
            rp_new = (rp_up > rp_tgt) ? rp_tgt : rp_up;
        end else if (rp_cur > rp_tgt) begin
            rp_new = (rp_dn < rp_tgt) ? rp_tgt : rp_dn;
        end else begin
            rp_new = rp_cur;
        end
    end

    // Error accumulator updates, each saturating at the signed 32-bit range.
    logic signed [35:0] wheel_sum;
    logic signed [35:0] speed_err;
    logic signed [31:0] speed_acc_new;
    logic signed [31:0] turn_acc_new;
    logic signed [31:0] line_sum_new;

    always_comb begin
        wheel_sum     = 36'(r_left) + 36'(r_right);
        speed_err     = 36'(r_speed_acc) + 36'(r_ideal_speed) - (wheel_sum <<< 7);
        speed_acc_new = ddpid_pkg::sat32(ddpid_pkg::SAT_IN_W'(speed_err));
        turn_acc_new  = ddpid_pkg::sat32(ddpid_pkg::SAT_IN_W'(r_turn_acc)
                                         + ddpid_pkg::SAT_IN_W'(r_gyro));
        line_sum_new  = ddpid_pkg::sat32(ddpid_pkg::SAT_IN_W'(r_line_sum)
                                         + ddpid_pkg::SAT_IN_W'(r_linepos));
    end

    // Wheel voltages: linear plus or minus angular, where angular is the floor of the sum / 256.
    logic signed [ddpid_pkg::ACC_W-1:0] ang_full;
    logic signed [31:0] volt_l;
    logic signed [31:0] volt_r;
    logic signed [31:0] vc;

    always_comb begin
        ang_full = mac_acc >>> 8;
        volt_l   = ddpid_pkg::sat32(ddpid_pkg::SAT_IN_W'(r_lin)
                                    + ddpid_pkg::SAT_IN_W'(ang_full));
        volt_r   = ddpid_pkg::sat32(ddpid_pkg::SAT_IN_W'(r_lin)
                                    - ddpid_pkg::SAT_IN_W'(ang_full));
        vc       = r_side ? r_vr : r_vl;
    end

    // PWM mapping of the finished quotient: offset by stop, minimum if v is nonzero, saturated.
    logic [48:0] pwm_sum;
    logic [11:0] pwm_val;

    always_comb begin
        pwm_sum = STOP_W + 49'(div_quo);
        if ((vc != 32'sd0) && (pwm_sum < MIN_W)) begin
            pwm_sum = MIN_W;
        end
        if (pwm_sum > MAX_W) begin
            pwm_sum = MAX_W;
        end
        pwm_val = pwm_sum[11:0];
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ddpid_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = i_in.running ? ddpid_pkg::S_RAMP : ddpid_pkg::S_DONE;
                end
            end
            ddpid_pkg::S_RAMP:      n_state = ddpid_pkg::S_ERR;
            ddpid_pkg::S_ERR:       n_state = ddpid_pkg::S_LIN_MAC;
            ddpid_pkg::S_LIN_MAC: begin
                if (r_cnt == lin_last) begin
                    n_state = ddpid_pkg::S_LIN_DRAIN;
                end
            end
            ddpid_pkg::S_LIN_DRAIN: begin
                n_state = pct_mode ? ddpid_pkg::S_LIN_DIVS : ddpid_pkg::S_LIN_SAVE;
            end
            ddpid_pkg::S_LIN_SAVE:  n_state = ddpid_pkg::S_ANG_MAC;
            ddpid_pkg::S_LIN_DIVS:  n_state = ddpid_pkg::S_LIN_DIVW;
            ddpid_pkg::S_LIN_DIVW: begin
                if (div_stat.done) begin
                    n_state = ddpid_pkg::S_ANG_MAC;
                end
            end
            ddpid_pkg::S_ANG_MAC: begin
                if (r_cnt == 3'd4) begin
                    n_state = ddpid_pkg::S_ANG_DRAIN;
                end
            end
            ddpid_pkg::S_ANG_DRAIN: n_state = ddpid_pkg::S_VOLT;
            ddpid_pkg::S_VOLT:      n_state = ddpid_pkg::S_PWM_MAC;
            ddpid_pkg::S_PWM_MAC:   n_state = ddpid_pkg::S_PWM_DRAIN;
            ddpid_pkg::S_PWM_DRAIN: n_state = ddpid_pkg::S_PWM_DIVS;
            ddpid_pkg::S_PWM_DIVS:  n_state = ddpid_pkg::S_PWM_DIVW;
            ddpid_pkg::S_PWM_DIVW: begin
                if (div_stat.done) begin
                    n_state = r_side ? ddpid_pkg::S_DONE : ddpid_pkg::S_PWM_MAC;
                end
            end
            ddpid_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = ddpid_pkg::S_IDLE;
                end
            end
            default:                n_state = ddpid_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, MAC operands and divider start.
    always_comb begin
        i_in.ready    = 1'b0;
        mac_ctl.clear = 1'b0;
        mac_ctl.valid = 1'b0;
        mac_a         = '0;
        mac_b         = '0;
        div_start     = 1'b0;
        div_dividend  = mac_acc[ddpid_pkg::DIV_W-1:0];
        div_divisor   = r_batt;
        case (r_state)
            ddpid_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
            end
            ddpid_pkg::S_ERR: begin
                mac_ctl.clear = 1'b1;
            end
            ddpid_pkg::S_LIN_MAC: begin
                mac_ctl.valid = 1'b1;
                if (pct_mode) begin
                    mac_a = FULL_MV;
                    mac_b = 34'(r_ideal_pct);
                end else if (r_cnt == 3'd0) begin
                    mac_a = 18'(r_lin_gains[15:0]);
                    mac_b = 34'(r_speed_acc);
                end else begin
                    mac_a = 18'(r_lin_gains[31:16]);
                    mac_b = 34'(r_speed_acc) - 34'(r_prev_speed);
                end
            end
            ddpid_pkg::S_LIN_SAVE: begin
                mac_ctl.clear = 1'b1;
            end
            ddpid_pkg::S_LIN_DIVS: begin
                mac_ctl.clear = 1'b1;
                div_start     = 1'b1;
                div_dividend  = ddpid_pkg::DIV_W'(mac_acc >>> 8);
                div_divisor   = ddpid_pkg::PCT_DIVISOR;
            end
            ddpid_pkg::S_ANG_MAC: begin
                mac_ctl.valid = 1'b1;
                case (r_cnt)
                    3'd0: begin
                        mac_a = 18'(r_ang_gains[15:0]);
                        mac_b = 34'(r_turn_acc);
                    end
                    3'd1: begin
                        mac_a = 18'(r_ang_gains[31:16]);
                        mac_b = 34'(r_turn_acc) - 34'(r_prev_turn);
                    end
                    3'd2: begin
                        mac_a = 18'(r_line_gains[15:0]);
                        mac_b = 34'(r_line_now);
                    end
                    3'd3: begin
                        mac_a = 18'(r_line_gains[31:16]);
                        mac_b = 34'(r_line_sum);
                    end
                    default: begin
                        mac_a = 18'(r_line_gains[47:32]);
                        mac_b = 34'(r_line_now) - 34'(r_line_prev);
                    end
                endcase
            end
            ddpid_pkg::S_VOLT: begin
                mac_ctl.clear = 1'b1;
            end
            ddpid_pkg::S_PWM_MAC: begin
                mac_ctl.valid = 1'b1;
                mac_a         = HALF_PWM;
                mac_b         = (vc > 32'sd0) ? 34'(vc) : '0;
            end
            ddpid_pkg::S_PWM_DIVS: begin
                mac_ctl.clear = 1'b1;
                div_start     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer state and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddpid_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Configuration writes.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags      <= '0;
            r_tgt_speed  <= '0;
            r_tgt_pct    <= '0;
            r_accel      <= '0;
            r_brake      <= '0;
            r_lin_gains  <= '0;
            r_ang_gains  <= '0;
            r_line_gains <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (ddpid_pkg::t_reg_idx'(i_cfg.index))
                ddpid_pkg::REG_FLAGS:          r_flags      <= i_cfg.data[2:0];
                ddpid_pkg::REG_TARGET_SPEED:   r_tgt_speed  <= $signed(i_cfg.data[15:0]);
                ddpid_pkg::REG_TARGET_PERCENT: r_tgt_pct    <= i_cfg.data[6:0];
                ddpid_pkg::REG_ACCEL_STEP:     r_accel      <= i_cfg.data[15:0];
                ddpid_pkg::REG_BRAKE_STEP:     r_brake      <= i_cfg.data[15:0];
                ddpid_pkg::REG_LINEAR_GAINS:   r_lin_gains  <= i_cfg.data[31:0];
                ddpid_pkg::REG_ANGULAR_GAINS:  r_ang_gains  <= i_cfg.data[31:0];
                ddpid_pkg::REG_LINE_GAINS:     r_line_gains <= i_cfg.data[47:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state: changes only on running ticks, in the ramp and error steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ideal_speed <= '0;
            r_ideal_pct   <= '0;
            r_speed_acc   <= '0;
            r_prev_speed  <= '0;
            r_turn_acc    <= '0;
            r_prev_turn   <= '0;
            r_line_now    <= '0;
            r_line_prev   <= '0;
            r_line_sum    <= '0;
        end else if (r_state == ddpid_pkg::S_RAMP) begin
            if (pct_mode) begin
                r_ideal_pct <= rp_new[31:0];
            end else begin
                r_ideal_speed <= rp_new[31:0];
            end
        end else if (r_state == ddpid_pkg::S_ERR) begin
            if (!pct_mode) begin
                r_prev_speed <= r_speed_acc;
                r_speed_acc  <= speed_acc_new;
            end
            // The previous turn error always follows, so with gyro correction off
            // the derivative term goes to zero while the proportional one stays.
            r_prev_turn <= r_turn_acc;
            if (r_flags[ddpid_pkg::FLAG_GYRO]) begin
                r_turn_acc <= turn_acc_new;
            end
            if (r_flags[ddpid_pkg::FLAG_LINE]) begin
                r_line_prev <= r_line_now;
                r_line_now  <= r_linepos;
                r_line_sum  <= line_sum_new;
            end
        end
    end

    // Working registers of one tick.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_left    <= i_in.left_speed;
            r_right   <= i_in.right_speed;
            r_gyro    <= i_in.gyro_rate;
            r_linepos <= i_in.line_position;
            // A zero battery reading is treated as one millivolt.
            r_batt    <= (i_in.battery_mv == '0) ? 14'd1 : i_in.battery_mv;
            r_stopped <= !i_in.running;
            r_side    <= 1'b0;
            r_pwm_l   <= STOP_PWM;
            r_pwm_r   <= STOP_PWM;
        end
        if (r_state == ddpid_pkg::S_LIN_SAVE) begin
            r_lin <= 48'(mac_acc >>> 16);
        end
        if ((r_state == ddpid_pkg::S_LIN_DIVW) && div_stat.done) begin
            r_lin <= $signed(div_quo);
        end
        if (r_state == ddpid_pkg::S_VOLT) begin
            r_vl <= volt_l;
            r_vr <= volt_r;
        end
        if ((r_state == ddpid_pkg::S_PWM_DIVW) && div_stat.done) begin
            if (r_side) begin
                r_pwm_r <= pwm_val;
            end else begin
                r_pwm_l <= pwm_val;
            end
            r_side <= 1'b1;
        end
    end

    // Output register: holds a finished result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_l    <= r_pwm_l;
            r_out_r    <= r_pwm_r;
            r_out_stop <= r_stopped;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.left_duty  = r_out_l;
    assign o_out.right_duty = r_out_r;
    assign o_out.stopped    = r_out_stop;

`ifndef ASSERT_OFF
    // A tick that is not running goes straight to the result step.
    a_stop_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_in.running) |=> (r_state == ddpid_pkg::S_DONE))
        else $error("stop tick did not go straight to the result step");

    // The divider is never started while it is still busy.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A divide completes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ddpid_pkg::S_LIN_DIVW
                           || r_state == ddpid_pkg::S_PWM_DIVW))
        else $error("divide finished outside a wait step");

    // A stopped result always carries the stop value on both wheels.
    a_stop_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stopped) |-> (o_out.left_duty == STOP_PWM
                                             && o_out.right_duty == STOP_PWM))
        else $error("stopped result with non-stop PWM");
`endif

endmodule

[test/ddpid_pwm_checker.sv]
// Checker that predicts the PWM pair of every control tick and compares the result transfers.
`timescale 1ns / 1ps

module ddpid_pwm_checker #(
    parameter int unsigned PWM_MAX         = 4095,
    parameter int unsigned PWM_STOP        = 0,
    parameter int unsigned PWM_MIN         = 0,
    parameter int unsigned FULL_BATTERY_MV = 8400
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ddpid_in_if   tick_ch,
    ddpid_cfg_if  cfg_ch,
    ddpid_out_if  pwm_ch,
    output int    o_mismatches,
    output int    o_outstanding
);

    localparam longint PMAX  = PWM_MAX;
    localparam longint PSTOP = PWM_STOP;
    localparam longint PMIN  = PWM_MIN;
    localparam longint FULL  = FULL_BATTERY_MV;

    typedef struct packed {
        logic [ddpid_pkg::PWM_W-1:0] left;
        logic [ddpid_pkg::PWM_W-1:0] right;
        logic                        stopped;
    } t_pwm_pair;

    t_pwm_pair pwm_expected_q[$];

    // Register copies.
    logic [2:0]         flags;
    logic signed [15:0] tgt_speed;
    logic [6:0]         tgt_pct;
    logic [15:0]        accel, brake;
    logic [31:0]        lin_g, ang_g;
    logic [47:0]        line_g;

    // Controller state copies.
    longint ideal_spd, ideal_pct, spd_acc, spd_prev, turn_acc, turn_prev;
    longint line_now, line_prev, line_sum;
    int     mismatches;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
        return q;
    endfunction

    // Move toward the target by one accel or brake step, never past it.
    function automatic longint ramp_to(longint cur, longint tgt);
        longint c;
        c = cur;
        if (c < tgt) begin
            c = c + longint'(accel);
            if (c > tgt) c = tgt;
        end else if (c > tgt) begin
            c = c - longint'(brake);
            if (c < tgt) c = tgt;
        end
        return clamp32(c);
    endfunction

    function automatic logic [ddpid_pkg::PWM_W-1:0] volt_to_pwm(longint v, longint batt);
        longint p, vc;
        p = PSTOP;
        vc = clamp32(v);
        if (vc > 0) p = p + floor_quot(vc * (PMAX / 2), batt);
        if (vc != 0 && p < PMIN) p = PMIN;
        if (p > PMAX) p = PMAX;
        if (p < 0) p = 0;
        return p[ddpid_pkg::PWM_W-1:0];
    endfunction

    task automatic predict_pwm_tick();
        longint lspd, rspd, gyro, lpos, batt, lin_v, ang_v, acc, kp, kd, stop;
        t_pwm_pair res;
        lspd = tick_ch.left_speed;
        rspd = tick_ch.right_speed;
        gyro = tick_ch.gyro_rate;
        lpos = tick_ch.line_position;
        batt = tick_ch.battery_mv;
        if (!tick_ch.running) begin
            stop = (PSTOP > PMAX) ? PMAX : PSTOP;
            res = '{stop[ddpid_pkg::PWM_W-1:0], stop[ddpid_pkg::PWM_W-1:0], 1'b1};
            pwm_expected_q.push_back(res);
            return;
        end
        if (batt == 0) batt = 1;

        if (flags[ddpid_pkg::FLAG_PERCENT]) begin
            kp = tgt_pct;
            ideal_pct = ramp_to(ideal_pct, kp * 256);
            lin_v = floor_quot(FULL * ideal_pct, 25600);
        end else begin
            kp = lin_g[15:0];
            kd = lin_g[31:16];
            ideal_spd = ramp_to(ideal_spd, longint'(tgt_speed) * 256);
            spd_prev = spd_acc;
            spd_acc = clamp32(spd_acc + ideal_spd - (lspd + rspd) * 128);
            lin_v = floor_quot(kp * spd_acc + kd * (spd_acc - spd_prev), 65536);
        end

        // The gyro derivative collapses to zero when its correction is off.
        turn_prev = turn_acc;
        if (flags[ddpid_pkg::FLAG_GYRO]) turn_acc = clamp32(turn_acc + gyro);

        if (flags[ddpid_pkg::FLAG_LINE]) begin
            line_prev = line_now;
            line_now = lpos;
            line_sum = clamp32(line_sum + lpos);
        end

        acc = longint'(ang_g[15:0]) * turn_acc
            + longint'(ang_g[31:16]) * (turn_acc - turn_prev)
            + longint'(line_g[15:0]) * line_now
            + longint'(line_g[31:16]) * line_sum
            + longint'(line_g[47:32]) * (line_now - line_prev);
        ang_v = floor_quot(acc, 256);

        res = '{volt_to_pwm(lin_v + ang_v, batt), volt_to_pwm(lin_v - ang_v, batt), 1'b0};
        pwm_expected_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_pwm_pair want;
        if (!i_rst_n) begin
            flags = '0; tgt_speed = '0; tgt_pct = '0; accel = '0; brake = '0;
            lin_g = '0; ang_g = '0; line_g = '0;
            ideal_spd = 0; ideal_pct = 0; spd_acc = 0; spd_prev = 0;
            turn_acc = 0; turn_prev = 0; line_now = 0; line_prev = 0; line_sum = 0;
            pwm_expected_q.delete();
            mismatches = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (ddpid_pkg::t_reg_idx'(cfg_ch.index))
                    ddpid_pkg::REG_FLAGS:          flags = cfg_ch.data[2:0];
                    ddpid_pkg::REG_TARGET_SPEED:   tgt_speed = cfg_ch.data[15:0];
                    ddpid_pkg::REG_TARGET_PERCENT: tgt_pct = cfg_ch.data[6:0];
                    ddpid_pkg::REG_ACCEL_STEP:     accel = cfg_ch.data[15:0];
                    ddpid_pkg::REG_BRAKE_STEP:     brake = cfg_ch.data[15:0];
                    ddpid_pkg::REG_LINEAR_GAINS:   lin_g = cfg_ch.data[31:0];
                    ddpid_pkg::REG_ANGULAR_GAINS:  ang_g = cfg_ch.data[31:0];
                    ddpid_pkg::REG_LINE_GAINS:     line_g = cfg_ch.data[47:0];
                    default: ;
                endcase
            end
            if (pwm_ch.valid && pwm_ch.ready) begin
                if (pwm_expected_q.size() == 0) begin
                    $display("%0t: unexpected result %0d/%0d/%0d", $time,
                             pwm_ch.left_duty, pwm_ch.right_duty, pwm_ch.stopped);
                    mismatches++;
                end else begin
                    want = pwm_expected_q.pop_front();
                    if (pwm_ch.left_duty !== want.left) begin
                        $display("%0t: left_duty expected %0d actual %0d", $time,
                                 want.left, pwm_ch.left_duty);
                        mismatches++;
                    end
                    if (pwm_ch.right_duty !== want.right) begin
                        $display("%0t: right_duty expected %0d actual %0d", $time,
                                 want.right, pwm_ch.right_duty);
                        mismatches++;
                    end
                    if (pwm_ch.stopped !== want.stopped) begin
                        $display("%0t: stopped expected %0d actual %0d", $time,
                                 want.stopped, pwm_ch.stopped);
                        mismatches++;
                    end
                end
            end
            if (tick_ch.valid && tick_ch.ready) predict_pwm_tick();
        end
        o_mismatches  <= mismatches;
        o_outstanding <= pwm_expected_q.size();
    end

endmodule

[test/tb_diff_drive_pid_motor_control.sv]
// Top of the testbench: clock, reset, tick and register stimulus, and the final verdict.
`timescale 1ns / 1ps

module tb_diff_drive_pid_motor_control;

    // Cycles without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   mismatches;
    int   outstanding;
    int   quiet;

    ddpid_in_if  tick_ch ();
    ddpid_cfg_if cfg_ch ();
    ddpid_out_if pwm_ch ();

    diff_drive_pid_motor_control dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .i_cfg   (cfg_ch),
        .o_out   (pwm_ch)
    );

    ddpid_pwm_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .tick_ch       (tick_ch),
        .cfg_ch        (cfg_ch),
        .pwm_ch        (pwm_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // The result side stalls with a probability of twelve percent, except in the calm window.
    always @(posedge i_clk) begin
        pwm_ch.ready <= calm || ($urandom_range(99) >= 12);
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) || (pwm_ch.valid && pwm_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Random gaps before a tick; valid is lowered only while a gap is taken.
    task automatic idle_gap();
        while (!calm && $urandom_range(99) < 12) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_tick(input logic run, input logic [15:0] lspd, input logic [15:0] rspd,
                             input logic [15:0] gyro, input logic [15:0] lpos,
                             input logic [13:0] batt);
        idle_gap();
        tick_ch.valid         <= 1'b1;
        tick_ch.running       <= run;
        tick_ch.left_speed    <= lspd;
        tick_ch.right_speed   <= rspd;
        tick_ch.gyro_rate     <= gyro;
        tick_ch.line_position <= lpos;
        tick_ch.battery_mv    <= batt;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    // Moderate values, the two extremes and fully random words, in a random mix.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return 16'($urandom_range(400) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [13:0] pick_battery();
        case ($urandom_range(9))
            0:       return 14'($urandom);
            1:       return 14'($urandom_range(1, 16383) | (1 << $urandom_range(13)));
            default: return 14'($urandom_range(6000, 8400));
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($urandom_range(1024));
    endfunction

    task automatic send_random_tick();
        send_tick($urandom_range(9) != 0, pick_word(), pick_word(), pick_word(), pick_word(),
                  pick_battery());
    endtask

    // The sender holds off until every expected result has come back.
    task automatic drain();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Leaves valid high; the caller lowers it after the last write of a burst.
    task automatic write_reg(input ddpid_pkg::t_reg_idx idx, input logic [47:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic write_all(input logic [47:0] fl, input logic [47:0] ts, input logic [47:0] tp,
                             input logic [47:0] ac, input logic [47:0] br,
                             input logic [47:0] lg, input logic [47:0] ag,
                             input logic [47:0] ng);
        write_reg(ddpid_pkg::REG_FLAGS, fl);
        write_reg(ddpid_pkg::REG_TARGET_SPEED, ts);
        write_reg(ddpid_pkg::REG_TARGET_PERCENT, tp);
        write_reg(ddpid_pkg::REG_ACCEL_STEP, ac);
        write_reg(ddpid_pkg::REG_BRAKE_STEP, br);
        write_reg(ddpid_pkg::REG_LINEAR_GAINS, lg);
        write_reg(ddpid_pkg::REG_ANGULAR_GAINS, ag);
        write_reg(ddpid_pkg::REG_LINE_GAINS, ng);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_random_config();
        logic [15:0] ts;
        ts = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(600) - 300);
        write_all(48'($urandom_range(7)), {32'($urandom), ts}, 48'($urandom_range(100)),
                  48'(($urandom_range(3) == 0) ? $urandom : $urandom_range(2048)),
                  48'(($urandom_range(3) == 0) ? $urandom : $urandom_range(2048)),
                  {16'($urandom), pick_gain(), pick_gain()},
                  {16'($urandom), pick_gain(), pick_gain()},
                  {pick_gain(), 16'($urandom_range(16)), pick_gain()});
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        calm                 <= 1'b0;
        tick_ch.valid        <= 1'b0;
        tick_ch.running      <= 1'b0;
        tick_ch.left_speed   <= '0;
        tick_ch.right_speed  <= '0;
        tick_ch.gyro_rate    <= '0;
        tick_ch.line_position <= '0;
        tick_ch.battery_mv   <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: a stopped tick, a zero battery, and the field extremes.
        send_tick(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 14'h3FFF);
        send_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 14'h0000);
        send_tick(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 14'h0001);
        drain();

        // Every register but the target percent at its maximum, all corrections on.
        write_all(48'h7, 48'h7FFF, 48'd100, 48'hFFFF, 48'hFFFF, 48'hFFFF_FFFF,
                  48'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_tick(1'b1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 14'h3FFF);
        send_tick(1'b1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 14'h0000);
        send_tick(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 14'h0001);
        send_tick(1'b1, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 14'h0001);
        send_tick(1'b1, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 14'h3FFF);
        drain();

        // Percent mode ramps up toward the top, then brakes back to zero.
        write_all(48'h1, 48'h8000, 48'd100, 48'd3000, 48'd5000, 48'h0100_0100,
                  48'h0, 48'h0);
        repeat (6) send_tick(1'b1, 16'd10, 16'd10, 16'd0, 16'd0, 14'd8400);
        drain();
        write_all(48'h1, 48'h8000, 48'd0, 48'd3000, 48'd5000, 48'h0100_0100, 48'h0, 48'h0);
        repeat (4) send_tick(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 14'd7000);
        drain();

        // Encoder mode braking toward the lowest target, gyro and line off but gains set.
        write_all(48'h0, 48'h8000, 48'd0, 48'd100, 48'd40000, 48'h0040_0200,
                  48'h0100_0200, 48'h0080_0004_0100);
        repeat (4) send_tick(1'b1, 16'h8000, 16'h7FFF, 16'd300, 16'hFF00, 14'd8000);
        drain();

        // Random phases, each under its own register setting; one runs with no idling.
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                write_all(48'($urandom_range(7)), 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0,
                          48'h0);
            end else begin
                write_random_config();
            end
            calm <= (ph == 4);
            repeat (100) send_random_tick();
            drain();
        end
        calm <= 1'b0;

        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
